/* hw/rtl/bstl_pkg.sv */
// Package: shared types and constants for the binary STL triangle deframer.
package bstl_pkg;

  localparam int HEADER_BYTES_DEF = 80;
  localparam int HDR_POS_W        = 7;
  localparam int LANE_W           = 4;
  localparam int WORD_W           = 32;
  localparam int COMP_N           = 3;

  localparam logic [LANE_W-1:0] LANE_COUNT_END = 4'd3;
  localparam logic [LANE_W-1:0] LANE_VEC_END   = 4'd11;
  localparam logic [LANE_W-1:0] LANE_ATTR_END  = 4'd1;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_V0     = 2'd1,
    KIND_V1     = 2'd2,
    KIND_V2     = 2'd3
  } bstl_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0] vector_z;
    logic [WORD_W-1:0] vector_y;
    logic [WORD_W-1:0] vector_x;
    bstl_kind_t        vector_kind;
    logic [WORD_W-1:0] triangle_number;
    logic [WORD_W-1:0] declared_count;
    logic              last_of_triangle;
    logic              beyond_count;
  } bstl_res_t;

endpackage

/* hw/rtl/binary_stl_triangle_deframer.sv */
// Top level: binary STL triangle deframer with input and result registers.
//
// Channel | Dir | Payload
// in_*    | in  | tdata: byte_value[7:0]; tuser: file_start
// out_*   | out | tdata: x, y, z, triangle_number, declared_count; tuser: kind,
//         |     | beyond_count; tlast: last_of_triangle
//
// One byte per cycle unless a result stalls; results pass byte then result reg.
// Throughput is set by the single byte register feeding the framer counters.
// Reset (rst_n low, synchronous) empties both registers and restarts at byte 0.
// A stalled result holds the byte register only when the next byte also emits.
module binary_stl_triangle_deframer
  import bstl_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] byte_value
  input  logic         in_tuser,   // [0] file_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // x, y, z, triangle_number, declared_count
  output logic [2:0]   out_tuser,  // [1:0] vector_kind, [2] beyond_count
  output logic         out_tlast
);

  logic      s1_vld_r;
  logic [7:0] s1_byte_r;
  logic      s1_start_r;
  logic      s1_go;
  logic      emit;
  bstl_res_t res;
  logic      out_vld_r, out_vld_nxt;
  bstl_res_t out_r;

  bstl_framer #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_go),
    .byte_value (s1_byte_r),
    .file_start (s1_start_r),
    .emit       (emit),
    .res        (res)
  );

  assign s1_go     = s1_vld_r && (!emit || !out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  always_comb begin
    if (s1_go && emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.declared_count, out_r.triangle_number,
                       out_r.vector_z, out_r.vector_y, out_r.vector_x};
  assign out_tuser  = {out_r.beyond_count, out_r.vector_kind};
  assign out_tlast  = out_r.last_of_triangle;

endmodule

/* hw/rtl/bstl_framer.sv */
// Framer: header skip, count assembly, record cutting and vector assembly.
module bstl_framer
  import bstl_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_value,
  input  logic       file_start,
  output logic       emit,
  output bstl_res_t  res
);

  localparam logic [HDR_POS_W-1:0] HDR_END = HDR_POS_W'(HEADER_BYTES);

  logic [HDR_POS_W-1:0] hdr_r, hdr_nxt;
  logic [LANE_W-1:0]    lane_r, lane_nxt;
  bstl_kind_t           vec_r, vec_nxt;
  logic                 in_rec_r, in_rec_nxt;
  logic                 attr_r, attr_nxt;
  logic [WORD_W-1:0]    tri_r, tri_nxt;
  logic [WORD_W-1:0]    count_r, count_nxt;
  logic [WORD_W-1:0]    word_r [COMP_N];
  logic [WORD_W-1:0]    word_nxt [COMP_N];

  // state as seen by this byte; a file start clears it first
  logic [HDR_POS_W-1:0] hdr_e;
  logic [LANE_W-1:0]    lane_e;
  bstl_kind_t           vec_e;
  logic                 in_rec_e;
  logic                 attr_e;
  logic [WORD_W-1:0]    tri_e;

  always_comb begin
    hdr_e    = file_start ? '0 : hdr_r;
    lane_e   = file_start ? '0 : lane_r;
    vec_e    = file_start ? KIND_NORMAL : vec_r;
    in_rec_e = file_start ? 1'b0 : in_rec_r;
    attr_e   = file_start ? 1'b0 : attr_r;
    tri_e    = file_start ? '0 : tri_r;
  end

  always_comb begin
    hdr_nxt    = hdr_e;
    lane_nxt   = lane_e;
    vec_nxt    = vec_e;
    in_rec_nxt = in_rec_e;
    attr_nxt   = attr_e;
    tri_nxt    = tri_e;
    count_nxt  = count_r;
    word_nxt   = word_r;
    emit       = 1'b0;
    if (hdr_e < HDR_END) begin
      hdr_nxt = hdr_e + 1'b1;
    end else if (!in_rec_e) begin
      count_nxt[8*lane_e[1:0] +: 8] = byte_value;
      if (lane_e == LANE_COUNT_END) begin
        lane_nxt   = '0;
        in_rec_nxt = 1'b1;
      end else begin
        lane_nxt = lane_e + 1'b1;
      end
    end else if (!attr_e) begin
      for (int i = 0; i < COMP_N; i++) begin
        if (lane_e[3:2] == 2'(i)) begin
          word_nxt[i][8*lane_e[1:0] +: 8] = byte_value;
        end
      end
      if (lane_e == LANE_VEC_END) begin
        emit     = 1'b1;
        lane_nxt = '0;
        vec_nxt  = bstl_kind_t'(vec_e + 1'b1);
        attr_nxt = (vec_e == KIND_V2);
      end else begin
        lane_nxt = lane_e + 1'b1;
      end
    end else begin
      if (lane_e == LANE_ATTR_END) begin
        lane_nxt = '0;
        attr_nxt = 1'b0;
        tri_nxt  = tri_e + 1'b1;
      end else begin
        lane_nxt = lane_e + 1'b1;
      end
    end
  end

  always_comb begin
    res.vector_x         = word_r[0];
    res.vector_y         = word_r[1];
    res.vector_z         = {byte_value, word_r[2][23:0]};
    res.vector_kind      = vec_e;
    res.triangle_number  = tri_e;
    res.declared_count   = count_r;
    res.last_of_triangle = (vec_e == KIND_V2);
    res.beyond_count     = (tri_e >= count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r    <= '0;
      lane_r   <= '0;
      vec_r    <= KIND_NORMAL;
      in_rec_r <= 1'b0;
      attr_r   <= 1'b0;
      tri_r    <= '0;
    end else if (step) begin
      hdr_r    <= hdr_nxt;
      lane_r   <= lane_nxt;
      vec_r    <= vec_nxt;
      in_rec_r <= in_rec_nxt;
      attr_r   <= attr_nxt;
      tri_r    <= tri_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      count_r <= count_nxt;
      word_r  <= word_nxt;
    end
  end

endmodule

/* hw/rtl/bstl_chk.sv */
// Checker: port-level assertions for the deframer, bound to the top level.
module bstl_chk
  import bstl_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [7:0]   in_tdata,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (out_tuser[1:0] == KIND_V2))
    else $error("tlast does not match third vertex");

  a_beyond: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2] == (out_tdata[127:96] >= out_tdata[159:128]))
    else $error("beyond_count does not match triangle number");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind binary_stl_triangle_deframer bstl_chk u_bstl_chk (.*);
